[rtl/core/fpas_pkg.sv]
// shared types and constants of the frame pacer with auto skip
package fpas_pkg;

    localparam int TICK_WIDTH_DEF = 48;
    localparam int ACC_W          = 64;
    localparam int FREQ_W         = 32;
    localparam int RATE_W         = 10;
    localparam int SKIP_W         = 8;
    localparam int PROD_W         = FREQ_W + SKIP_W;
    localparam int DIV_STEPS      = ACC_W;
    localparam int MUL_STEPS      = RATE_W;
    localparam int CNT_W          = $clog2(DIV_STEPS);
    localparam int APB_DW         = 32;
    localparam int APB_AW         = 4;
    localparam int REG_IDX_W      = 2;

    localparam logic [REG_IDX_W-1:0] REG_FREQ = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_RATE = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_AUTO = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_MAXS = 2'd3;

    localparam logic [FREQ_W-1:0] FREQ_RST = 32'd1000;
    localparam logic [RATE_W-1:0] RATE_RST = 10'd60;
    localparam logic              AUTO_RST = 1'b0;
    localparam logic [SKIP_W-1:0] MAXS_RST = 8'd16;

    typedef struct packed {
        logic [FREQ_W-1:0] freq;
        logic [RATE_W-1:0] rate;
        logic              auto_en;
        logic [SKIP_W-1:0] max_skips;
    } t_cfg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIVD,
        S_CMP,
        S_MUL,
        S_MULX,
        S_DIVQ,
        S_SKN,
        S_SKA,
        S_SKM,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic div_step;
        logic cmp;
        logic mul_start;
        logic mul_step;
        logic resync;
        logic divq_start;
        logic skip_n;
        logic skip_add;
        logic skip_max;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic div_last;
        logic mul_last;
        logic late;
        logic skip_ok;
    } t_sts;

endpackage

[rtl/core/frame_pacer_auto_skip_unit.sv]
// frame pacer with auto skip: top level
// one word per frame, one item at a time; a radix-2 divider computes the deadline
// early frame: divide, compare, then load the result into the output register
// late frame: adds a 10-step shift-add multiply; with skip, a divide and skip steps
// next input word taken the cycle after the result enters the output register
// synchronous active-low reset: registers to defaults, accumulator and skips to zero
module frame_pacer_auto_skip_unit #(
    parameter int TICK_WIDTH = fpas_pkg::TICK_WIDTH_DEF,
    parameter int IN_DW      = ((TICK_WIDTH + 2 + 7) / 8) * 8,
    parameter int OUT_DW     = ((TICK_WIDTH + 10 + 7) / 8) * 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    // elapsed_ticks, wait_request, skip_allowed
    input  logic [IN_DW-1:0]             i_s_tdata,
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    // is_late, skip_count, deadline_ticks, must_wait
    output logic [OUT_DW-1:0]            o_m_tdata,
    input  logic                         i_psel,
    input  logic                         i_penable,
    input  logic                         i_pwrite,
    input  logic [fpas_pkg::APB_AW-1:0]  i_paddr,
    input  logic [fpas_pkg::APB_DW-1:0]  i_pwdata,
    output logic [fpas_pkg::APB_DW-1:0]  o_prdata,
    output logic                         o_pready
);
    import fpas_pkg::*;

    t_cfg                  cfg;
    logic                  clear;
    t_cmd                  cmd;
    t_sts                  sts;
    logic                  is_late;
    logic [SKIP_W-1:0]     skip_count;
    logic [TICK_WIDTH-1:0] deadline;
    logic                  must_wait;

    assign o_m_tdata = OUT_DW'({must_wait, deadline, skip_count, is_late});

    fpas_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (i_psel),
        .i_penable (i_penable),
        .i_pwrite  (i_pwrite),
        .i_paddr   (i_paddr),
        .i_pwdata  (i_pwdata),
        .o_prdata  (o_prdata),
        .o_pready  (o_pready),
        .o_cfg     (cfg),
        .o_clear   (clear)
    );

    fpas_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    fpas_dp #(
        .TICK_WIDTH (TICK_WIDTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_clear      (clear),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_elapsed    (i_s_tdata[TICK_WIDTH-1:0]),
        .i_wait       (i_s_tdata[TICK_WIDTH]),
        .i_skip       (i_s_tdata[TICK_WIDTH+1]),
        .o_is_late    (is_late),
        .o_skip_count (skip_count),
        .o_deadline   (deadline),
        .o_must_wait  (must_wait)
    );

endmodule

[rtl/core/fpas_regs.sv]
// configuration registers behind the apb port
module fpas_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_psel,
    input  logic                         i_penable,
    input  logic                         i_pwrite,
    input  logic [fpas_pkg::APB_AW-1:0]  i_paddr,
    input  logic [fpas_pkg::APB_DW-1:0]  i_pwdata,
    output logic [fpas_pkg::APB_DW-1:0]  o_prdata,
    output logic                         o_pready,
    output fpas_pkg::t_cfg               o_cfg,
    output logic                         o_clear
);
    import fpas_pkg::*;

    t_cfg                 r_cfg;
    t_cfg                 n_cfg;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] idx;

    assign idx      = i_paddr[APB_AW-1:2];
    assign wr_en    = i_psel & i_penable & i_pwrite;
    assign o_pready = 1'b1;
    assign o_clear  = wr_en;
    assign o_cfg    = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            case (idx)
                REG_FREQ: n_cfg.freq      = i_pwdata[FREQ_W-1:0];
                REG_RATE: n_cfg.rate      = i_pwdata[RATE_W-1:0];
                REG_AUTO: n_cfg.auto_en   = i_pwdata[0];
                REG_MAXS: n_cfg.max_skips = i_pwdata[SKIP_W-1:0];
                default:  n_cfg           = r_cfg;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_FREQ: o_prdata = APB_DW'(r_cfg.freq);
            REG_RATE: o_prdata = APB_DW'(r_cfg.rate);
            REG_AUTO: o_prdata = APB_DW'(r_cfg.auto_en);
            REG_MAXS: o_prdata = APB_DW'(r_cfg.max_skips);
            default:  o_prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.freq      <= FREQ_RST;
            r_cfg.rate      <= RATE_RST;
            r_cfg.auto_en   <= AUTO_RST;
            r_cfg.max_skips <= MAXS_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

[rtl/core/fpas_ctrl.sv]
// sequencing state machine of the frame pacer
module fpas_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_tvalid,
    output logic           o_s_tready,
    output logic           o_m_tvalid,
    input  logic           i_m_tready,
    input  fpas_pkg::t_sts i_sts,
    output fpas_pkg::t_cmd o_cmd
);
    import fpas_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_ovalid;
    logic   n_ovalid;
    logic   out_free;

    assign out_free   = !r_ovalid || i_m_tready;
    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_ovalid;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_s_tvalid) n_state = S_DIVD;
            S_DIVD: if (i_sts.div_last) n_state = S_CMP;
            S_CMP:  n_state = i_sts.late ? S_MUL : S_DONE;
            S_MUL:  if (i_sts.mul_last) n_state = S_MULX;
            S_MULX: n_state = i_sts.skip_ok ? S_DIVQ : S_DONE;
            S_DIVQ: if (i_sts.div_last) n_state = S_SKN;
            S_SKN:  n_state = S_SKA;
            S_SKA:  n_state = S_SKM;
            S_SKM:  n_state = S_DONE;
            S_DONE: if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            S_IDLE: o_cmd.load       = i_s_tvalid;
            S_DIVD: o_cmd.div_step   = 1'b1;
            S_CMP: begin
                o_cmd.cmp       = 1'b1;
                o_cmd.mul_start = i_sts.late;
            end
            S_MUL:  o_cmd.mul_step   = 1'b1;
            S_MULX: begin
                o_cmd.divq_start = i_sts.skip_ok;
                o_cmd.resync     = !i_sts.skip_ok;
            end
            S_DIVQ: o_cmd.div_step   = 1'b1;
            S_SKN:  o_cmd.skip_n     = 1'b1;
            S_SKA:  o_cmd.skip_add   = 1'b1;
            S_SKM:  o_cmd.skip_max   = 1'b1;
            S_DONE: o_cmd.out_load   = out_free;
            default: o_cmd = '0;
        endcase
    end

    always_comb begin
        n_ovalid = r_ovalid;
        if (o_cmd.out_load) begin
            n_ovalid = 1'b1;
        end else if (i_m_tready) begin
            n_ovalid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

endmodule

[rtl/core/fpas_dp.sv]
// pacer datapath: accumulator, shared divider, shift-add multiplier, result word
module fpas_dp #(
    parameter int TICK_WIDTH = fpas_pkg::TICK_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  fpas_pkg::t_cfg                i_cfg,
    input  logic                          i_clear,
    input  fpas_pkg::t_cmd                i_cmd,
    output fpas_pkg::t_sts                o_sts,
    input  logic [TICK_WIDTH-1:0]         i_elapsed,
    input  logic                          i_wait,
    input  logic                          i_skip,
    output logic                          o_is_late,
    output logic [fpas_pkg::SKIP_W-1:0]   o_skip_count,
    output logic [TICK_WIDTH-1:0]         o_deadline,
    output logic                          o_must_wait
);
    import fpas_pkg::*;

    logic [ACC_W-1:0]      r_acc,      n_acc;
    logic [SKIP_W-1:0]     r_skips,    n_skips;
    logic [TICK_WIDTH-1:0] r_now;
    logic                  r_wait;
    logic                  r_skip;
    logic [ACC_W-1:0]      r_dq,       n_dq;
    logic [FREQ_W-1:0]     r_rem,      n_rem;
    logic                  r_dsel,     n_dsel;
    logic [CNT_W-1:0]      r_cnt,      n_cnt;
    logic [ACC_W-1:0]      r_mcand,    n_mcand;
    logic [RATE_W-1:0]     r_mplier,   n_mplier;
    logic [ACC_W-1:0]      r_snow,     n_snow;
    logic [ACC_W-1:0]      r_deadline;
    logic                  r_late;
    logic                  r_must;
    logic [PROD_W-1:0]     r_prod;
    logic                  r_o_late;
    logic [SKIP_W-1:0]     r_o_skips;
    logic [TICK_WIDTH-1:0] r_o_dl;
    logic                  r_o_must;

    logic [RATE_W-1:0]     rate_eff;
    logic [FREQ_W-1:0]     freq_eff;
    logic [FREQ_W-1:0]     divisor;
    logic [FREQ_W:0]       div_trial;
    logic [FREQ_W:0]       div_diff;
    logic                  div_ge;
    logic [ACC_W-1:0]      now_ext;
    logic [ACC_W-1:0]      acc_add;
    logic [SKIP_W-1:0]     skip_n;

    assign rate_eff  = (i_cfg.rate == '0) ? RATE_W'(1) : i_cfg.rate;
    assign freq_eff  = (i_cfg.freq == '0) ? FREQ_W'(1) : i_cfg.freq;
    assign divisor   = r_dsel ? freq_eff : FREQ_W'(rate_eff);
    assign div_trial = {r_rem, r_dq[ACC_W-1]};
    assign div_diff  = div_trial - {1'b0, divisor};
    assign div_ge    = div_trial >= {1'b0, divisor};
    assign now_ext   = ACC_W'(r_now);
    assign acc_add   = r_acc + ACC_W'(i_cfg.freq);
    assign skip_n    = (r_dq >= ACC_W'(i_cfg.max_skips)) ? i_cfg.max_skips
                                                        : r_dq[SKIP_W-1:0] + SKIP_W'(1);

    assign o_sts.div_last = (r_cnt == CNT_W'(DIV_STEPS - 1));
    assign o_sts.mul_last = (r_cnt == CNT_W'(MUL_STEPS - 1));
    assign o_sts.late     = now_ext > r_dq;
    assign o_sts.skip_ok  = r_skip & i_cfg.auto_en;

    assign o_is_late    = r_o_late;
    assign o_skip_count = r_o_skips;
    assign o_deadline   = r_o_dl;
    assign o_must_wait  = r_o_must;

    always_comb begin
        n_acc    = r_acc;
        n_skips  = r_skips;
        n_dq     = r_dq;
        n_rem    = r_rem;
        n_dsel   = r_dsel;
        n_cnt    = r_cnt;
        n_mcand  = r_mcand;
        n_mplier = r_mplier;
        n_snow   = r_snow;
        if (i_clear) begin
            n_acc   = '0;
            n_skips = '0;
        end
        if (i_cmd.load) begin
            n_acc  = acc_add;
            n_dq   = acc_add;
            n_rem  = '0;
            n_dsel = 1'b0;
            n_cnt  = '0;
        end
        if (i_cmd.div_step) begin
            n_dq  = {r_dq[ACC_W-2:0], div_ge};
            n_rem = div_ge ? div_diff[FREQ_W-1:0] : div_trial[FREQ_W-1:0];
            n_cnt = r_cnt + CNT_W'(1);
        end
        if (i_cmd.mul_start) begin
            n_mcand  = now_ext;
            n_mplier = rate_eff;
            n_snow   = '0;
            n_cnt    = '0;
        end
        if (i_cmd.mul_step) begin
            if (r_mplier[0]) begin
                n_snow = r_snow + r_mcand;
            end
            n_mcand  = {r_mcand[ACC_W-2:0], 1'b0};
            n_mplier = {1'b0, r_mplier[RATE_W-1:1]};
            n_cnt    = r_cnt + CNT_W'(1);
        end
        if (i_cmd.resync) begin
            n_acc = r_snow;
        end
        if (i_cmd.divq_start) begin
            n_dq   = r_snow - r_acc;
            n_rem  = '0;
            n_dsel = 1'b1;
            n_cnt  = '0;
        end
        if (i_cmd.skip_n) begin
            n_skips = skip_n;
        end
        if (i_cmd.skip_add) begin
            n_acc = r_acc + ACC_W'(r_prod);
        end
        if (i_cmd.skip_max) begin
            if (r_acc < r_snow) begin
                n_acc = r_snow;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc   <= '0;
            r_skips <= '0;
        end else begin
            r_acc   <= n_acc;
            r_skips <= n_skips;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dq     <= n_dq;
        r_rem    <= n_rem;
        r_dsel   <= n_dsel;
        r_cnt    <= n_cnt;
        r_mcand  <= n_mcand;
        r_mplier <= n_mplier;
        r_snow   <= n_snow;
        if (i_cmd.load) begin
            r_now  <= i_elapsed;
            r_wait <= i_wait;
            r_skip <= i_skip;
        end
        if (i_cmd.cmp) begin
            r_deadline <= r_dq;
            r_late     <= o_sts.late;
            r_must     <= !o_sts.late && r_wait;
        end
        if (i_cmd.skip_n) begin
            r_prod <= PROD_W'(i_cfg.freq) * PROD_W'(skip_n);
        end
        if (i_cmd.out_load) begin
            r_o_late  <= r_late;
            r_o_skips <= r_skips;
            r_o_dl    <= r_deadline[TICK_WIDTH-1:0];
            r_o_must  <= r_must;
        end
    end

endmodule

[tb/sv/tb_top.sv]
// self-checking testbench for the frame pacer with auto skip
module tb_top;
    import fpas_pkg::*;

    localparam int IN_DW          = 56;
    localparam int OUT_DW         = 64;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PRINT_LIMIT    = 40;
    localparam int TAIL_CYCLES    = 160;

    typedef enum int {
        TK_EARLY,
        TK_EXACT,
        TK_JUST_LATE,
        TK_LATE_FRAMES,
        TK_LATE_HUGE,
        TK_NOISE
    } t_tick_kind;

    typedef struct packed {
        logic        late;
        logic [7:0]  skips;
        logic [47:0] deadline;
        logic        must_wait;
    } t_frame_verdict;

    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 i_s_tvalid = 1'b0;
    logic                 o_s_tready;
    // elapsed_ticks, wait_request, skip_allowed
    logic [IN_DW-1:0]     i_s_tdata  = '0;
    logic                 o_m_tvalid;
    logic                 i_m_tready = 1'b0;
    // is_late, skip_count, deadline_ticks, must_wait
    logic [OUT_DW-1:0]    o_m_tdata;
    logic                 i_psel     = 1'b0;
    logic                 i_penable  = 1'b0;
    logic                 i_pwrite   = 1'b0;
    logic [APB_AW-1:0]    i_paddr    = '0;
    logic [APB_DW-1:0]    i_pwdata   = '0;
    logic [APB_DW-1:0]    o_prdata;
    logic                 o_pready;

    frame_pacer_auto_skip_unit DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .i_psel     (i_psel),
        .i_penable  (i_penable),
        .i_pwrite   (i_pwrite),
        .i_paddr    (i_paddr),
        .i_pwdata   (i_pwdata),
        .o_prdata   (o_prdata),
        .o_pready   (o_pready)
    );

    always #4 i_clk = ~i_clk;

    logic [FREQ_W-1:0] cfg_freq  = FREQ_RST;
    logic [RATE_W-1:0] cfg_rate  = RATE_RST;
    logic              cfg_auto  = AUTO_RST;
    logic [SKIP_W-1:0] cfg_maxs  = MAXS_RST;
    logic [63:0]       pace_acc   = '0;
    logic [7:0]        pace_skips = '0;

    t_frame_verdict verdict_q[$];
    t_frame_verdict want;
    logic [OUT_DW-1:0] got;

    int errors      = 0;
    int burst_left  = 0;
    int idle_cycles = 0;
    int rx_stall    = 0;
    int rx_cycle    = 0;
    logic rx_calm   = 1'b0;

    task automatic report_mismatch(input string what, input logic [63:0] seen,
                                   input logic [63:0] exp_val);
        if (errors < PRINT_LIMIT)
            $display("ERROR %s: got %0h want %0h", what, seen, exp_val);
        errors++;
    endtask

    function automatic logic [63:0] pace_rate();
        return (cfg_rate == 0) ? 64'd1 : {54'd0, cfg_rate};
    endfunction

    function automatic t_frame_verdict advance_pacer(input logic [47:0] now_in,
                                                     input logic wr, input logic sk);
        logic [63:0] now, rate, freq, fdiv, dl, snow, q, n, lim;
        t_frame_verdict v;
        now  = {16'd0, now_in};
        rate = pace_rate();
        freq = {32'd0, cfg_freq};
        fdiv = (cfg_freq == 0) ? 64'd1 : freq;
        lim  = {56'd0, cfg_maxs};
        pace_acc = pace_acc + freq;
        dl = pace_acc / rate;
        v.late = now > dl;
        v.must_wait = 1'b0;
        if (v.late) begin
            snow = now * rate;
            if (sk && cfg_auto) begin
                q = (snow - pace_acc) / fdiv;
                n = (q >= lim) ? lim : q + 64'd1;
                pace_skips = n[7:0];
                pace_acc = pace_acc + freq * {56'd0, pace_skips};
                if (pace_acc < snow)
                    pace_acc = snow;
            end else begin
                pace_acc = snow;
            end
        end else begin
            v.must_wait = wr;
        end
        v.skips = pace_skips;
        v.deadline = dl[47:0];
        return v;
    endfunction

    // tick value chosen around the deadline the next frame will see, or random noise
    function automatic logic [47:0] pick_ticks(input t_tick_kind kind);
        logic [63:0] dl, span, off, t;
        dl   = (pace_acc + {32'd0, cfg_freq}) / pace_rate();
        span = {32'd0, cfg_freq} / pace_rate() + 64'd1;
        case (kind)
            TK_EARLY: begin
                off = 64'($urandom) % span;
                t = (dl > off) ? dl - off : 64'd0;
            end
            TK_EXACT:       t = dl;
            TK_JUST_LATE:   t = dl + 64'd1;
            TK_LATE_FRAMES: t = dl + span * 64'($urandom_range(1, 40));
            TK_LATE_HUGE:   t = dl + ({$urandom, $urandom} >> $urandom_range(16, 40));
            default:        t = {$urandom, $urandom};
        endcase
        return t[47:0];
    endfunction

    task automatic send_frame(input logic [47:0] now, input logic wr, input logic sk);
        int gap;
        i_s_tdata  <= {6'd0, sk, wr, now};
        i_s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!o_s_tready);
        verdict_q.push_back(advance_pacer(now, wr, sk));
        if (burst_left == 0) begin
            burst_left = $urandom_range(0, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
            if (gap != 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end else begin
            burst_left--;
        end
    endtask

    task automatic drain_verdicts();
        i_s_tvalid <= 1'b0;
        burst_left = 0;
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] val);
        drain_verdicts();
        i_psel    <= 1'b1;
        i_penable <= 1'b0;
        i_pwrite  <= 1'b1;
        i_paddr   <= {idx, 2'b00};
        i_pwdata  <= val;
        @(posedge i_clk);
        i_penable <= 1'b1;
        do @(posedge i_clk); while (!o_pready);
        i_psel    <= 1'b0;
        i_penable <= 1'b0;
        case (idx)
            REG_FREQ: cfg_freq = val[FREQ_W-1:0];
            REG_RATE: cfg_rate = val[RATE_W-1:0];
            REG_AUTO: cfg_auto = val[0];
            REG_MAXS: cfg_maxs = val[SKIP_W-1:0];
            default: ;
        endcase
        pace_acc   = '0;
        pace_skips = '0;
        @(posedge i_clk);
    endtask

    task automatic test_default_config();
        send_frame(48'd0, 1'b1, 1'b0);
        send_frame(48'd0, 1'b0, 1'b1);
        send_frame(pick_ticks(TK_EXACT), 1'b1, 1'b1);
        send_frame(pick_ticks(TK_JUST_LATE), 1'b1, 1'b1);
        send_frame(48'hFFFF_FFFF_FFFF, 1'b0, 1'b1);
        send_frame(48'd0, 1'b1, 1'b0);
        drain_verdicts();
    endtask

    task automatic test_skip_clamp();
        write_reg(REG_AUTO, 32'd1);
        write_reg(REG_MAXS, 32'd16);
        write_reg(REG_FREQ, 32'd1000);
        write_reg(REG_RATE, 32'd60);
        send_frame(pick_ticks(TK_JUST_LATE), 1'b0, 1'b1);
        send_frame(pick_ticks(TK_LATE_FRAMES), 1'b1, 1'b1);
        send_frame(pick_ticks(TK_EXACT) + 48'd600, 1'b0, 1'b1);
        send_frame(pick_ticks(TK_LATE_FRAMES), 1'b0, 1'b0);
        send_frame(pick_ticks(TK_EARLY), 1'b1, 1'b1);
        write_reg(REG_MAXS, 32'd0);
        send_frame(pick_ticks(TK_LATE_FRAMES), 1'b0, 1'b1);
        write_reg(REG_MAXS, 32'hFFFF_FFFF);
        send_frame(48'hFFFF_FFFF_FFFF, 1'b1, 1'b1);
        drain_verdicts();
    endtask

    task automatic test_zero_and_wide_settings();
        write_reg(REG_FREQ, 32'd0);
        send_frame(48'd0, 1'b1, 1'b1);
        send_frame(48'd5, 1'b0, 1'b1);
        send_frame(48'd5, 1'b1, 1'b1);
        write_reg(REG_RATE, 32'd0);
        write_reg(REG_FREQ, 32'hFFFF_FFFF);
        send_frame(pick_ticks(TK_EXACT), 1'b1, 1'b0);
        send_frame(pick_ticks(TK_LATE_FRAMES), 1'b0, 1'b1);
        write_reg(REG_RATE, 32'd1023);
        send_frame(pick_ticks(TK_JUST_LATE), 1'b1, 1'b1);
        send_frame(pick_ticks(TK_LATE_HUGE), 1'b0, 1'b1);
        drain_verdicts();
    endtask

    task automatic test_random_frames();
        logic [31:0] v;
        int r;
        t_tick_kind kind;
        for (int phase = 0; phase < 8; phase++) begin
            case ($urandom_range(0, 5))
                0: v = 32'd1;
                1: v = 32'hFFFF_FFFF;
                2: v = 32'd1000;
                3: v = $urandom_range(1, 65535);
                4: v = $urandom;
                default: v = 32'd0;
            endcase
            write_reg(REG_FREQ, v);
            case ($urandom_range(0, 4))
                0: v = 32'd1;
                1: v = 32'd1023;
                2: v = 32'd60;
                3: v = $urandom;
                default: v = $urandom_range(1, 1023);
            endcase
            write_reg(REG_RATE, v);
            case ($urandom_range(0, 2))
                0: v = 32'd0;
                1: v = 32'd255;
                default: v = $urandom;
            endcase
            write_reg(REG_MAXS, v);
            v = ($urandom & 32'hFFFF_FFFE) | 32'(($urandom_range(0, 3) != 0));
            write_reg(REG_AUTO, v);
            for (int k = 0; k < 90; k++) begin
                r = $urandom_range(0, 99);
                if (r < 25)      kind = TK_EARLY;
                else if (r < 30) kind = TK_EXACT;
                else if (r < 35) kind = TK_JUST_LATE;
                else if (r < 75) kind = TK_LATE_FRAMES;
                else if (r < 85) kind = TK_LATE_HUGE;
                else             kind = TK_NOISE;
                send_frame(pick_ticks(kind), 1'($urandom), 1'($urandom_range(0, 4) != 0));
            end
            drain_verdicts();
        end
    endtask

    always @(posedge i_clk) begin
        rx_cycle++;
        if (rx_cycle % 512 == 0)
            rx_calm = ($urandom_range(0, 2) == 0);
        if (rx_calm) begin
            i_m_tready <= 1'b1;
        end else if (rx_stall > 0) begin
            i_m_tready <= 1'b0;
            rx_stall--;
        end else begin
            i_m_tready <= 1'b1;
            if ($urandom_range(0, 5) == 0)
                rx_stall = $urandom_range(1, 20);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = o_m_tdata;
            if (verdict_q.size() == 0) begin
                report_mismatch("unexpected word", got, 64'd0);
            end else begin
                want = verdict_q.pop_front();
                if (got[0] != want.late)
                    report_mismatch("is_late", 64'(got[0]), 64'(want.late));
                if (got[8:1] != want.skips)
                    report_mismatch("skip_count", 64'(got[8:1]), 64'(want.skips));
                if (got[56:9] != want.deadline)
                    report_mismatch("deadline_ticks", 64'(got[56:9]), 64'(want.deadline));
                if (got[57] != want.must_wait)
                    report_mismatch("must_wait", 64'(got[57]), 64'(want.must_wait));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) || (i_psel && i_penable))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_default_config();
        test_skip_clamp();
        test_zero_and_wide_settings();
        test_random_frames();
        drain_verdicts();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (verdict_q.size() != 0)
            report_mismatch("words never delivered", 64'(verdict_q.size()), 64'd0);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
